// File: rtl/core/bcd_clock_alarm_with_digit_entry_core_assert.svh
// Assertion macros used by the alarm clock checker.
`ifndef BCD_CLOCK_ALARM_WITH_DIGIT_ENTRY_CORE_ASSERT_SVH
`define BCD_CLOCK_ALARM_WITH_DIGIT_ENTRY_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BCDCLK_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("alarm clock check failed");

// Next-cycle implication, disabled during reset.
`define BCDCLK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("alarm clock check failed");

`endif

// File: rtl/core/bcdclk_pkg.sv
// Types and constants for the BCD alarm clock core.
package bcdclk_pkg;

  // Operation codes carried in s_tuser
  localparam logic [1:0] OP_BASE_TICK = 2'd0;
  localparam logic [1:0] OP_TONE_TICK = 2'd1;
  localparam logic [1:0] OP_KEY_PRESS = 2'd2;

  // Key codes
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_PAUSE     = 4'd10;
  localparam logic [3:0] KEY_RESUME    = 4'd11;
  localparam logic [3:0] KEY_SET_TIME  = 4'd12;
  localparam logic [3:0] KEY_SET_ALARM = 4'd13;
  localparam logic [3:0] KEY_STOP      = 4'd15;

  // Configuration register indexes
  localparam logic [1:0] CFG_TICKS_PER_COUNT  = 2'd0;
  localparam logic [1:0] CFG_BLINK_TICKS      = 2'd1;
  localparam logic [1:0] CFG_TONE_ON_TICKS    = 2'd2;
  localparam logic [1:0] CFG_TONE_CYCLE_TICKS = 2'd3;

  // Register reset values
  localparam logic [7:0]  TICKS_PER_COUNT_RST  = 8'd20;
  localparam logic [7:0]  BLINK_TICKS_RST      = 8'd5;
  localparam logic [11:0] TONE_ON_TICKS_RST    = 12'd400;
  localparam logic [11:0] TONE_CYCLE_TICKS_RST = 12'd1200;

  // Result word layout
  localparam int RESULT_W      = 24;
  localparam int BIT_SETTING   = 13;
  localparam int BIT_CURSOR_LO = 14;
  localparam int BIT_RINGING   = 18;
  localparam int BIT_ARMED     = 17;

  // HH:MM as four BCD digits, each as wide as its range needs
  typedef struct packed {
    logic [1:0] h10;
    logic [3:0] h1;
    logic [2:0] m10;
    logic [3:0] m1;
  } digits_t;

endpackage

// File: rtl/core/bcd_clock_alarm_with_digit_entry_core.sv
// 24-hour BCD alarm clock core with digit entry and tone generator.
// One result per accepted item, registered into the output register, or into the skid entry when that is stalled.
// Throughput: one item per cycle while the skid entry is empty; a two-entry output buffer
// keeps s_tready high while one result waits, and the state update is a single registered pass.
// Reset (rst, synchronous, active high): time and alarm 00:00, clock running,
// counters cleared, registers at 20/5/400/1200, output buffer empty.
module bcd_clock_alarm_with_digit_entry_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,   // [3:0] key, [7:4] zero
  input  logic [1:0]                           s_tuser,   // [1:0] op
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [1:0] shown_hour_tens, [5:2] shown_hour_units, [8:6] shown_minute_tens,
  // [12:9] shown_minute_units, [13] setting_active, [15:14] cursor,
  // [16] blink_phase, [17] alarm_armed, [18] ringing, [19] tone_level,
  // [20] clock_running, [23:21] zero
  output logic [bcdclk_pkg::RESULT_W-1:0]      m_tdata,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [11:0]                          cfg_data
);
  import bcdclk_pkg::*;

  // Configuration registers
  logic [7:0]  ticks_per_count;
  logic [7:0]  blink_ticks;
  logic [11:0] tone_on_ticks;
  logic [11:0] tone_cycle_ticks;

  // Clock state
  digits_t     clock_digits, clock_digits_next;
  digits_t     alarm_digits, alarm_digits_next;
  digits_t     entry_digits, entry_digits_next;
  logic [1:0]  cursor_pos, cursor_pos_next;
  logic        in_setting, in_setting_next;
  logic        target_is_alarm, target_is_alarm_next;
  logic [7:0]  count_prescale, count_prescale_next;
  logic [7:0]  blink_count, blink_count_next;
  logic        blink_flag, blink_flag_next;
  logic        armed, armed_next;
  logic        tone_enable, tone_enable_next;
  logic        running, running_next;
  logic [11:0] tone_count, tone_count_next;
  logic        tone_pin, tone_pin_next;

  // Output buffer: main register plus one skid entry
  logic                out_valid;
  logic [RESULT_W-1:0] out_data;
  logic                skid_valid;
  logic [RESULT_W-1:0] skid_data;

  logic                s_xfer;
  logic                m_xfer;
  logic [1:0]          op;
  logic [3:0]          key;
  logic [RESULT_W-1:0] result;
  digits_t             shown;
  logic                digit_ok;
  logic [7:0]          blink_inc;
  logic [7:0]          prescale_inc;
  logic [11:0]         tone_inc;

  // Advance HH:MM by one minute with BCD carries and the 23:59 rollover.
  function automatic digits_t advance_minute(digits_t d);
    digits_t r;
    r = d;
    if (d.m1 == 4'd9) begin
      r.m1 = 4'd0;
      if (d.m10 == 3'd5) begin
        r.m10 = 3'd0;
        if (d.h1 == 4'd9) begin
          r.h1  = 4'd0;
          r.h10 = d.h10 + 2'd1;
        end else begin
          r.h1 = d.h1 + 4'd1;
        end
      end else begin
        r.m10 = d.m10 + 3'd1;
      end
    end else begin
      r.m1 = d.m1 + 4'd1;
    end
    if (r.h10 >= 2'd2 && r.h1 >= 4'd4) begin
      r.h10 = 2'd0;
      r.h1  = 4'd0;
    end
    return r;
  endfunction

  assign op        = s_tuser;
  assign key       = s_tdata[3:0];
  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign s_xfer    = s_tvalid && s_tready;
  assign m_xfer    = out_valid && m_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  assign blink_inc    = blink_count + 8'd1;
  assign prescale_inc = count_prescale + 8'd1;
  assign tone_inc     = tone_count + 12'd1;

  // Digit check for the current entry position
  always_comb begin
    unique case (cursor_pos)
      2'd0:    digit_ok = (key <= 4'd2);
      2'd1:    digit_ok = !(entry_digits.h10 == 2'd2 && key > 4'd3);
      2'd2:    digit_ok = (key <= 4'd5);
      default: digit_ok = 1'b1;
    endcase
  end

  // Next state for one item
  always_comb begin
    clock_digits_next    = clock_digits;
    alarm_digits_next    = alarm_digits;
    entry_digits_next    = entry_digits;
    cursor_pos_next      = cursor_pos;
    in_setting_next      = in_setting;
    target_is_alarm_next = target_is_alarm;
    count_prescale_next  = count_prescale;
    blink_count_next     = blink_count;
    blink_flag_next      = blink_flag;
    armed_next           = armed;
    tone_enable_next     = tone_enable;
    running_next         = running;
    tone_count_next      = tone_count;
    tone_pin_next        = tone_pin;

    unique case (op)
      OP_BASE_TICK: begin
        // Blink divider always counts; the minute prescaler only while running.
        if (blink_inc >= blink_ticks) begin
          blink_count_next = 8'd0;
          blink_flag_next  = !blink_flag;
        end else begin
          blink_count_next = blink_inc;
        end
        if (running) begin
          if (prescale_inc >= ticks_per_count) begin
            count_prescale_next = 8'd0;
            clock_digits_next   = advance_minute(clock_digits);
          end else begin
            count_prescale_next = prescale_inc;
          end
        end
      end
      OP_TONE_TICK: begin
        // Toggle the pin during the on part of each tone cycle.
        if (tone_enable && armed) begin
          if (tone_inc < tone_on_ticks) begin
            tone_count_next = tone_inc;
            tone_pin_next   = !tone_pin;
          end else if (tone_inc > tone_cycle_ticks) begin
            tone_count_next = 12'd0;
          end else begin
            tone_count_next = tone_inc;
          end
        end
      end
      OP_KEY_PRESS: begin
        if (in_setting) begin
          // Take a valid digit at the cursor; commit after the fourth.
          if (key <= KEY_DIGIT_MAX && digit_ok) begin
            unique case (cursor_pos)
              2'd0:    entry_digits_next.h10 = key[1:0];
              2'd1:    entry_digits_next.h1  = key;
              2'd2:    entry_digits_next.m10 = key[2:0];
              default: entry_digits_next.m1  = key;
            endcase
            cursor_pos_next = cursor_pos + 2'd1;
            if (cursor_pos == 2'd3) begin
              in_setting_next = 1'b0;
              if (target_is_alarm) begin
                alarm_digits_next = entry_digits_next;
                armed_next        = 1'b1;
              end else begin
                clock_digits_next   = entry_digits_next;
                count_prescale_next = 8'd0;
                running_next        = 1'b1;
              end
            end
          end
        end else begin
          unique case (key)
            KEY_SET_TIME, KEY_SET_ALARM: begin
              entry_digits_next    = clock_digits;
              cursor_pos_next      = 2'd0;
              in_setting_next      = 1'b1;
              target_is_alarm_next = (key == KEY_SET_ALARM);
              tone_enable_next     = 1'b0;
              if (key == KEY_SET_ALARM) begin
                armed_next = 1'b0;
              end
            end
            KEY_STOP: begin
              tone_enable_next = 1'b0;
              armed_next       = 1'b0;
            end
            KEY_PAUSE:  running_next = 1'b0;
            KEY_RESUME: running_next = 1'b1;
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    // Start ringing when the updated time meets the armed alarm.
    if (!in_setting_next && armed_next && clock_digits_next == alarm_digits_next) begin
      tone_enable_next = 1'b1;
    end
  end

  // Pack the result from the updated state
  always_comb begin
    shown  = in_setting_next ? entry_digits_next : clock_digits_next;
    result = {3'b000, running_next, tone_pin_next, tone_enable_next, armed_next,
              blink_flag_next, (in_setting_next ? cursor_pos_next : 2'd0),
              in_setting_next, shown.m1, shown.m10, shown.h1, shown.h10};
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_count  <= TICKS_PER_COUNT_RST;
      blink_ticks      <= BLINK_TICKS_RST;
      tone_on_ticks    <= TONE_ON_TICKS_RST;
      tone_cycle_ticks <= TONE_CYCLE_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TICKS_PER_COUNT:  ticks_per_count  <= cfg_data[7:0];
        CFG_BLINK_TICKS:      blink_ticks      <= cfg_data[7:0];
        CFG_TONE_ON_TICKS:    tone_on_ticks    <= cfg_data;
        CFG_TONE_CYCLE_TICKS: tone_cycle_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clock state, advanced on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_digits    <= '0;
      alarm_digits    <= '0;
      cursor_pos      <= 2'd0;
      in_setting      <= 1'b0;
      target_is_alarm <= 1'b0;
      count_prescale  <= 8'd0;
      blink_count     <= 8'd0;
      blink_flag      <= 1'b0;
      armed           <= 1'b0;
      tone_enable     <= 1'b0;
      running         <= 1'b1;
      tone_count      <= 12'd0;
      tone_pin        <= 1'b0;
    end else if (s_xfer) begin
      clock_digits    <= clock_digits_next;
      alarm_digits    <= alarm_digits_next;
      cursor_pos      <= cursor_pos_next;
      in_setting      <= in_setting_next;
      target_is_alarm <= target_is_alarm_next;
      count_prescale  <= count_prescale_next;
      blink_count     <= blink_count_next;
      blink_flag      <= blink_flag_next;
      armed           <= armed_next;
      tone_enable     <= tone_enable_next;
      running         <= running_next;
      tone_count      <= tone_count_next;
      tone_pin        <= tone_pin_next;
    end
  end

  // Entry digits are always loaded before they are shown; hold without reset.
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      entry_digits <= entry_digits_next;
    end
  end

  // Output buffer control: fill main register first, spill into skid when stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (s_xfer) begin
      if (!out_valid || m_xfer) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_xfer) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output buffer data
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      if (!out_valid || m_xfer) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end else if (m_xfer && skid_valid) begin
      out_data <= skid_data;
    end
  end

endmodule

// File: rtl/core/bcdclk_checker.sv
// Port-level checker for the alarm clock core, bound into the core module.
`include "bcd_clock_alarm_with_digit_entry_core_assert.svh"

module bcdclk_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [bcdclk_pkg::RESULT_W-1:0] m_tdata
);
  import bcdclk_pkg::*;

  // Cursor reads zero outside digit entry.
  `BCDCLK_ASSERT_NOW(a_cursor_idle, clk, rst, m_tvalid && !m_tdata[BIT_SETTING], m_tdata[BIT_CURSOR_LO+1:BIT_CURSOR_LO] == 2'd0)

  // Shown digits always stay in the 24-hour BCD ranges.
  `BCDCLK_ASSERT_NOW(a_digit_range, clk, rst, m_tvalid, m_tdata[1:0] <= 2'd2 && m_tdata[5:2] <= 4'd9 && m_tdata[8:6] <= 3'd5 && m_tdata[12:9] <= 4'd9)

  // Ringing only happens with the alarm armed.
  `BCDCLK_ASSERT_NOW(a_ring_armed, clk, rst, m_tvalid && m_tdata[BIT_RINGING], m_tdata[BIT_ARMED])

  // A stalled result holds.
  `BCDCLK_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind bcd_clock_alarm_with_digit_entry_core bcdclk_checker u_bcdclk_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
